// ===== rtl/itf_pkg.sv =====
// ----------------------------------------------------------------------------
// itf_pkg: shared types and constants for the integer text formatter
// Action codes, sign codes, sequencer states and ASCII digit lookup.
// ----------------------------------------------------------------------------
package itf_pkg;

  typedef enum logic [2:0] {
    ACT_SDEC = 3'd0,
    ACT_UDEC = 3'd1,
    ACT_HEX  = 3'd2,
    ACT_BIN  = 3'd3,
    ACT_PTR  = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    SIGN_NONE  = 2'd0,
    SIGN_PLUS  = 2'd1,
    SIGN_SPACE = 2'd2
  } sign_mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIZE,
    ST_LPAD,
    ST_PREFIX,
    ST_ZPAD,
    ST_DIGIT,
    ST_RPAD,
    ST_FLUSH
  } state_e;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;

  // BCD digits after the full 64-bit conversion
  localparam int unsigned DEC_DIGITS = 20;
  localparam int unsigned HEX_DIGITS = 16;
  localparam int unsigned BIN_DIGITS = 64;
  localparam int unsigned DIG_BITS   = 4 * DEC_DIGITS;

  localparam logic [7:0] DIGITS_LOWER [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
  };
  localparam logic [7:0] DIGITS_UPPER [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
    digit_char = upper ? DIGITS_UPPER[nib] : DIGITS_LOWER[nib];
  endfunction

endpackage

// ===== rtl/integer_text_formatter.sv =====
// ----------------------------------------------------------------------------
// integer_text_formatter
// Renders one 64-bit integer as printf-style ASCII text in packed groups.
// ----------------------------------------------------------------------------
// Input channel: one beat carries a value, its kind (signed or unsigned
// decimal, hex, binary, pointer) and the format flags. Output channel: each
// beat carries up to CHARS_PER_RESULT characters, first in the lowest byte,
// a character count, and last on the final group of the text.
// One item is worked on at a time; in_stall_o is high from acceptance until
// the final group has left the packer.
// Steps per item: decimal kinds first run the bit-serial binary-to-BCD
// shifter; every kind except pointer then drops leading zero digits, keeping
// at least one. After a sizing step the text leaves at one character per
// cycle through the left pad, prefix, zero pad, digit and right pad segments,
// pausing while a full group waits to move to the output register.
// A stalled output holds its beat; the packer fills behind it and then the
// character sequencer waits. Reset returns to idle and drops any output beat.
// ----------------------------------------------------------------------------
module integer_text_formatter #(
  parameter int unsigned CHARS_PER_RESULT = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [2:0]              action_i,
  input  logic [63:0]             value_i,
  input  logic                    left_align_i,
  input  logic [1:0]              sign_mode_i,
  input  logic                    zero_pad_i,
  input  logic                    upper_case_i,
  input  logic [7:0]              pad_width_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [63:0]             chars_o,
  output logic [3:0]              char_count_o,
  output logic                    last_o
);
  import itf_pkg::*;

  localparam logic [3:0] GroupChars = 4'(CHARS_PER_RESULT);
  localparam logic [5:0] ConvLast   = 6'd63;

  state_e state_q, state_d;

  action_e                act_q, act_d;
  logic                   left_q, left_d;
  logic                   zpad_q, zpad_d;
  logic                   upper_q, upper_d;
  logic [7:0]             width_q, width_d;
  logic [1:0]             plen_q, plen_d;
  logic [15:0]            pre_q, pre_d;
  logic [63:0]            val_q, val_d;
  logic [DIG_BITS-1:0]    sh_q, sh_d;
  logic [6:0]             ndig_q, ndig_d;
  logic [5:0]             bit_cnt_q, bit_cnt_d;
  logic [7:0]             pad_q, pad_d;
  logic [7:0]             rem_q, rem_d;

  logic [63:0]            pk_word_q, pk_word_d;
  logic [3:0]             pk_cnt_q, pk_cnt_d;
  logic                   pk_full_q, pk_full_d;
  logic                   pk_last_q, pk_last_d;

  logic                   out_valid_q, out_valid_d;
  logic [63:0]            out_chars_q, out_chars_d;
  logic [3:0]             out_cnt_q, out_cnt_d;
  logic                   out_last_q, out_last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pk_word_q   <= '0;
      pk_cnt_q    <= '0;
      pk_full_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pk_word_q   <= pk_word_d;
      pk_cnt_q    <= pk_cnt_d;
      pk_full_q   <= pk_full_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q       <= act_d;
    left_q      <= left_d;
    zpad_q      <= zpad_d;
    upper_q     <= upper_d;
    width_q     <= width_d;
    plen_q      <= plen_d;
    pre_q       <= pre_d;
    val_q       <= val_d;
    sh_q        <= sh_d;
    ndig_q      <= ndig_d;
    bit_cnt_q   <= bit_cnt_d;
    pad_q       <= pad_d;
    rem_q       <= rem_d;
    pk_last_q   <= pk_last_d;
    out_chars_q <= out_chars_d;
    out_cnt_q   <= out_cnt_d;
    out_last_q  <= out_last_d;
  end

  always_comb begin
    action_e             act_in;
    logic [63:0]         mag;
    logic                is_neg;
    logic [DIG_BITS-1:0] adj;
    logic [3:0]          d;
    logic                top_zero;
    logic [7:0]          total;
    logic [7:0]          zpad_cnt;
    logic [7:0]          rpad_cnt;
    logic [3:0]          nib;
    logic [7:0]          ch;
    logic                ch_last;
    logic                emit;
    logic                advance;
    logic [3:0]          cnt_inc;
    logic                out_free;

    state_d     = state_q;
    act_d       = act_q;
    left_d      = left_q;
    zpad_d      = zpad_q;
    upper_d     = upper_q;
    width_d     = width_q;
    plen_d      = plen_q;
    pre_d       = pre_q;
    val_d       = val_q;
    sh_d        = sh_q;
    ndig_d      = ndig_q;
    bit_cnt_d   = bit_cnt_q;
    pad_d       = pad_q;
    rem_d       = rem_q;
    pk_word_d   = pk_word_q;
    pk_cnt_d    = pk_cnt_q;
    pk_full_d   = pk_full_q;
    pk_last_d   = pk_last_q;
    out_valid_d = out_valid_q;
    out_chars_d = out_chars_q;
    out_cnt_d   = out_cnt_q;
    out_last_d  = out_last_q;

    // input decode
    act_in = (action_i > ACT_PTR) ? ACT_UDEC : action_e'(action_i);
    is_neg = (act_in == ACT_SDEC) && value_i[63];
    mag    = is_neg ? (64'd0 - value_i) : value_i;

    // double-dabble correction on every BCD digit
    for (int g = 0; g < DEC_DIGITS; g++) begin
      d = sh_q[g*4 +: 4];
      adj[g*4 +: 4] = (d >= 4'd5) ? (d + 4'd3) : d;
    end

    top_zero = (act_q == ACT_BIN) ? !sh_q[DIG_BITS-1] : (sh_q[DIG_BITS-1 -: 4] == 4'd0);
    total    = 8'(plen_q) + 8'(ndig_q);
    zpad_cnt = (!left_q && zpad_q) ? pad_q : 8'd0;
    rpad_cnt = left_q ? pad_q : 8'd0;

    nib = (act_q == ACT_BIN) ? {3'd0, sh_q[DIG_BITS-1]} : sh_q[DIG_BITS-1 -: 4];

    ch = CH_SPACE;
    case (state_q)
      ST_PREFIX: ch = (rem_q == 8'd2) ? pre_q[15:8] : pre_q[7:0];
      ST_ZPAD:   ch = CH_ZERO;
      ST_DIGIT:  ch = digit_char(nib, upper_q);
      default:   ch = CH_SPACE;
    endcase
    ch_last = (rem_q == 8'd1) &&
              ((state_q == ST_RPAD) || ((state_q == ST_DIGIT) && (rpad_cnt == 8'd0)));

    emit    = 1'b0;
    advance = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          act_d   = act_in;
          left_d  = left_align_i;
          zpad_d  = zero_pad_i;
          upper_d = upper_case_i && (act_in == ACT_HEX);
          width_d = pad_width_i;
          plen_d  = 2'd0;
          pre_d   = {CH_ZERO, CH_X};
          if (act_in == ACT_PTR) begin
            plen_d = 2'd2;
          end else if (is_neg) begin
            plen_d = 2'd1;
            pre_d  = {8'd0, CH_MINUS};
          end else if (sign_mode_i == SIGN_PLUS) begin
            plen_d = 2'd1;
            pre_d  = {8'd0, CH_PLUS};
          end else if (sign_mode_i == SIGN_SPACE) begin
            plen_d = 2'd1;
            pre_d  = {8'd0, CH_SPACE};
          end
          bit_cnt_d = '0;
          val_d     = mag;
          if (act_in == ACT_SDEC || act_in == ACT_UDEC) begin
            sh_d    = '0;
            ndig_d  = 7'(DEC_DIGITS);
            state_d = ST_CONV;
          end else begin
            sh_d    = {mag, 16'd0};
            ndig_d  = (act_in == ACT_BIN) ? 7'(BIN_DIGITS) : 7'(HEX_DIGITS);
            state_d = ST_SKIP;
          end
        end
      end
      ST_CONV: begin
        // shift one value bit into the BCD register per cycle
        sh_d      = {adj[DIG_BITS-2:0], val_q[63]};
        val_d     = {val_q[62:0], 1'b0};
        bit_cnt_d = bit_cnt_q + 6'd1;
        if (bit_cnt_q == ConvLast) begin
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // drop leading zero digits except for pointers, keep at least one
        if (act_q != ACT_PTR && ndig_q > 7'd1 && top_zero) begin
          sh_d   = (act_q == ACT_BIN) ? {sh_q[DIG_BITS-2:0], 1'b0}
                                      : {sh_q[DIG_BITS-5:0], 4'd0};
          ndig_d = ndig_q - 7'd1;
        end else begin
          state_d = ST_SIZE;
        end
      end
      ST_SIZE: begin
        pad_d   = (width_q > total) ? (width_q - total) : 8'd0;
        rem_d   = (width_q > total && !left_q && !zpad_q) ? (width_q - total) : 8'd0;
        state_d = ST_LPAD;
      end
      ST_LPAD, ST_PREFIX, ST_ZPAD, ST_DIGIT, ST_RPAD: begin
        if (rem_q == 8'd0) begin
          advance = 1'b1;
        end else if (!pk_full_q) begin
          emit  = 1'b1;
          rem_d = rem_q - 8'd1;
          if (rem_q == 8'd1) begin
            advance = 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (!pk_full_q) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (advance) begin
      case (state_q)
        ST_LPAD: begin
          state_d = ST_PREFIX;
          rem_d   = 8'(plen_q);
        end
        ST_PREFIX: begin
          state_d = ST_ZPAD;
          rem_d   = zpad_cnt;
        end
        ST_ZPAD: begin
          state_d = ST_DIGIT;
          rem_d   = 8'(ndig_q);
        end
        ST_DIGIT: begin
          state_d = ST_RPAD;
          rem_d   = rpad_cnt;
        end
        default: state_d = ST_FLUSH;
      endcase
    end

    // advance the digit shifter as each digit leaves
    if (emit && state_q == ST_DIGIT) begin
      sh_d = (act_q == ACT_BIN) ? {sh_q[DIG_BITS-2:0], 1'b0}
                                : {sh_q[DIG_BITS-5:0], 4'd0};
    end

    // move a full group into the output register
    out_free = !out_valid_q || !out_stall_i;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (pk_full_q && out_free) begin
      out_valid_d = 1'b1;
      out_chars_d = pk_word_q;
      out_cnt_d   = pk_cnt_q;
      out_last_d  = pk_last_q;
      pk_word_d   = '0;
      pk_cnt_d    = '0;
      pk_full_d   = 1'b0;
    end

    // pack one character per beat slot
    cnt_inc = pk_cnt_q + 4'd1;
    if (emit) begin
      pk_word_d[{pk_cnt_q[2:0], 3'b000} +: 8] = ch;
      pk_cnt_d  = cnt_inc;
      pk_last_d = ch_last;
      pk_full_d = (cnt_inc == GroupChars) || ch_last;
    end
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign chars_o      = out_chars_q;
  assign char_count_o = out_cnt_q;
  assign last_o       = out_last_q;

endmodule

// ===== bench/integer_text_formatter_tb.sv =====
// ----------------------------------------------------------------------------
// integer_text_formatter_tb: self-checking bench for the integer text formatter
// Drives formatted-integer requests, renders the expected ASCII text in the
// bench, splits it into eight-character groups and checks every output beat
// field by field. Runs with sender and receiver idling, then without.
// ----------------------------------------------------------------------------
module integer_text_formatter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import itf_pkg::*;

  localparam int unsigned CLK_PERIOD      = 8;
  localparam int unsigned CHARS_PER_GROUP = 8;
  localparam int unsigned QUIET_LIMIT     = 4000;
  localparam int unsigned TAIL_CYCLES     = 400;
  localparam int unsigned ITEMS_PER_PHASE = 62;
  // codes the package leaves unnamed: spare actions fall back to unsigned decimal
  localparam logic [2:0]  ACT_SPARE_FIRST = 3'd5;
  localparam logic [1:0]  SIGN_UNUSED     = 2'd3;

  typedef struct {
    logic [2:0]  action;
    logic [63:0] value;
    logic        left_align;
    logic [1:0]  sign_mode;
    logic        zero_pad;
    logic        upper_case;
    logic [7:0]  pad_width;
  } fmt_req_t;

  typedef struct {
    logic [63:0] chars;
    logic [3:0]  count;
    logic        last;
  } text_group_t;

  class text_scoreboard;
    text_group_t groups_due[$];
    int unsigned errors;

    function logic [7:0] hex_ascii(logic [3:0] nib, logic upper);
      if (nib < 4'd10) return CH_ZERO + 8'(nib);
      return (upper ? 8'h41 : 8'h61) + 8'(nib - 4'd10);
    endfunction

    // Render the text of one accepted request and queue its groups.
    function void render_item(fmt_req_t r);
      logic [7:0]  text[$];
      logic [7:0]  digits[$];
      logic [7:0]  prefix[$];
      logic [63:0] mag;
      logic [2:0]  act;
      logic        upper;
      int unsigned total, pad, pos, cnt;
      text_group_t g;
      mag = r.value;
      act = (r.action > ACT_PTR) ? 3'(ACT_UDEC) : r.action;
      upper = r.upper_case && (act == ACT_HEX);
      if (act == ACT_PTR) begin
        prefix.push_back(CH_ZERO);
        prefix.push_back(CH_X);
      end else if (act == ACT_SDEC && mag[63]) begin
        mag = -mag;
        prefix.push_back(CH_MINUS);
      end else if (r.sign_mode == SIGN_PLUS) begin
        prefix.push_back(CH_PLUS);
      end else if (r.sign_mode == SIGN_SPACE) begin
        prefix.push_back(CH_SPACE);
      end
      case (act)
        ACT_PTR: begin
          for (int i = 15; i >= 0; i--) digits.push_back(hex_ascii(mag[4*i +: 4], 1'b0));
        end
        ACT_HEX: begin
          do begin
            digits.push_front(hex_ascii(mag[3:0], upper));
            mag = mag >> 4;
          end while (mag != 0);
        end
        ACT_BIN: begin
          do begin
            digits.push_front(CH_ZERO + 8'(mag[0]));
            mag = mag >> 1;
          end while (mag != 0);
        end
        default: begin
          do begin
            digits.push_front(CH_ZERO + 8'(mag % 10));
            mag = mag / 10;
          end while (mag != 0);
        end
      endcase
      total = prefix.size() + digits.size();
      pad = (r.pad_width > total) ? r.pad_width - total : 0;
      if (!r.left_align && !r.zero_pad) repeat (pad) text.push_back(CH_SPACE);
      text = {text, prefix};
      if (!r.left_align && r.zero_pad) repeat (pad) text.push_back(CH_ZERO);
      text = {text, digits};
      if (r.left_align) repeat (pad) text.push_back(CH_SPACE);
      pos = 0;
      while (pos < text.size()) begin
        cnt = text.size() - pos;
        if (cnt > CHARS_PER_GROUP) cnt = CHARS_PER_GROUP;
        g.chars = '0;
        for (int i = 0; i < cnt; i++) g.chars[8*i +: 8] = text[pos + i];
        pos += cnt;
        g.count = 4'(cnt);
        g.last = (pos >= text.size());
        groups_due.push_back(g);
      end
    endfunction

    function void check_group(logic [63:0] chars, logic [3:0] count, logic last);
      text_group_t due;
      if (groups_due.size() == 0) begin
        $display("%0t: unexpected group chars=%h count=%0d last=%0b",
                 $time, chars, count, last);
        errors++;
        return;
      end
      due = groups_due.pop_front();
      if (chars !== due.chars) begin
        $display("%0t: chars expected %h actual %h", $time, due.chars, chars);
        errors++;
      end
      if (count !== due.count) begin
        $display("%0t: char_count expected %0d actual %0d", $time, due.count, count);
        errors++;
      end
      if (last !== due.last) begin
        $display("%0t: last expected %0b actual %0b", $time, due.last, last);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return groups_due.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  action_i;
  logic [63:0] value_i;
  logic        left_align_i;
  logic [1:0]  sign_mode_i;
  logic        zero_pad_i;
  logic        upper_case_i;
  logic [7:0]  pad_width_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [63:0] chars_o;
  logic [3:0]  char_count_o;
  logic        last_o;

  text_scoreboard sb;
  int unsigned    send_idle_pct;
  int unsigned    recv_idle_pct;

  integer_text_formatter #(
    .CHARS_PER_RESULT(CHARS_PER_GROUP)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .value_i     (value_i),
    .left_align_i(left_align_i),
    .sign_mode_i (sign_mode_i),
    .zero_pad_i  (zero_pad_i),
    .upper_case_i(upper_case_i),
    .pad_width_i (pad_width_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .chars_o     (chars_o),
    .char_count_o(char_count_o),
    .last_o      (last_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(negedge clk_i) begin
    if (rst_ni) out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_group(chars_o, char_count_o, last_o);
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic fmt_req_t format_req(logic [2:0] action, logic [63:0] value,
                                          logic left_align, logic [1:0] sign_mode,
                                          logic zero_pad, logic upper_case,
                                          logic [7:0] pad_width);
    fmt_req_t r;
    r.action     = action;
    r.value      = value;
    r.left_align = left_align;
    r.sign_mode  = sign_mode;
    r.zero_pad   = zero_pad;
    r.upper_case = upper_case;
    r.pad_width  = pad_width;
    return r;
  endfunction

  function automatic fmt_req_t random_item();
    fmt_req_t r;
    if ($urandom_range(9) == 0) r.action = ACT_SPARE_FIRST + 3'($urandom_range(2));
    else r.action = 3'($urandom_range(ACT_PTR));
    case ($urandom_range(5))
      0: r.value = 64'($urandom_range(99));
      1: r.value = {$urandom, $urandom};
      2: r.value = 64'd1 << $urandom_range(63);
      3: r.value = -64'($urandom_range(1000));
      4: r.value = {$urandom, $urandom} >> $urandom_range(63);
      default: r.value = ~64'($urandom_range(15));
    endcase
    r.left_align = 1'($urandom_range(1));
    r.sign_mode  = 2'($urandom_range(3));
    r.zero_pad   = 1'($urandom_range(1));
    r.upper_case = 1'($urandom_range(1));
    // keep most fields narrow; wide fields are slow and emit up to 32 groups
    if ($urandom_range(14) == 0) r.pad_width = 8'($urandom_range(255));
    else r.pad_width = 8'($urandom_range(24));
    return r;
  endfunction

  // Call at a falling edge; returns at the falling edge after the beat.
  task automatic send_item(input fmt_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    action_i     <= r.action;
    value_i      <= r.value;
    left_align_i <= r.left_align;
    sign_mode_i  <= r.sign_mode;
    zero_pad_i   <= r.zero_pad;
    upper_case_i <= r.upper_case;
    pad_width_i  <= r.pad_width;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.render_item(r);
    @(negedge clk_i);
  endtask

  // Hold off the sender until every queued group has come out.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    fmt_req_t plan[$];
    sb = new();
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    action_i     = '0;
    value_i      = '0;
    left_align_i = 1'b0;
    sign_mode_i  = '0;
    zero_pad_i   = 1'b0;
    upper_case_i = 1'b0;
    pad_width_i  = '0;
    out_stall_i  = 1'b0;
    send_idle_pct = 6;
    recv_idle_pct = 79;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    plan.push_back(format_req(ACT_SDEC, 64'd0, 0, SIGN_NONE, 0, 0, 8'd0));
    plan.push_back(format_req(ACT_SDEC, '1, 0, SIGN_PLUS, 0, 0, 8'd0));
    plan.push_back(format_req(ACT_SDEC, 64'h8000_0000_0000_0000, 0, SIGN_NONE, 0, 0, 8'd0));
    plan.push_back(format_req(ACT_SDEC, 64'h7FFF_FFFF_FFFF_FFFF, 0, SIGN_PLUS, 1, 0, 8'd25));
    plan.push_back(format_req(ACT_SDEC, -64'd5, 0, SIGN_SPACE, 1, 0, 8'd6));
    plan.push_back(format_req(ACT_UDEC, '1, 0, SIGN_NONE, 0, 0, 8'd0));
    plan.push_back(format_req(ACT_UDEC, 64'd42, 0, SIGN_SPACE, 0, 0, 8'd6));
    // left alignment beats zero padding
    plan.push_back(format_req(ACT_UDEC, 64'd42, 1, SIGN_PLUS, 1, 0, 8'd8));
    plan.push_back(format_req(ACT_UDEC, 64'd12345, 0, SIGN_NONE, 0, 0, 8'd3));
    plan.push_back(format_req(ACT_UDEC, 64'd7, 0, SIGN_UNUSED, 0, 0, 8'd3));
    plan.push_back(format_req(ACT_HEX, 64'hDEAD_BEEF, 0, SIGN_NONE, 1, 1, 8'd12));
    plan.push_back(format_req(ACT_HEX, '1, 0, SIGN_PLUS, 0, 0, 8'd0));
    plan.push_back(format_req(ACT_HEX, 64'd0, 1, SIGN_SPACE, 0, 1, 8'd4));
    plan.push_back(format_req(ACT_BIN, 64'd0, 0, SIGN_NONE, 0, 0, 8'd0));
    plan.push_back(format_req(ACT_BIN, '1, 0, SIGN_PLUS, 0, 1, 8'd0));
    plan.push_back(format_req(ACT_BIN, 64'd5, 1, SIGN_NONE, 0, 0, 8'd255));
    plan.push_back(format_req(ACT_PTR, 64'd0, 0, SIGN_PLUS, 0, 1, 8'd0));
    plan.push_back(format_req(ACT_PTR, 64'hABCD, 0, SIGN_SPACE, 1, 1, 8'd24));
    plan.push_back(format_req(ACT_PTR, 64'hFEDC_BA98_7654_3210, 1, SIGN_NONE, 0, 0, 8'd20));
    plan.push_back(format_req(ACT_SDEC, 64'd0, 0, SIGN_NONE, 0, 0, 8'd255));
    plan.push_back(format_req(ACT_SDEC, '1, 0, SIGN_NONE, 1, 0, 8'd255));
    for (int k = 0; k < 3; k++)
      plan.push_back(format_req(ACT_SPARE_FIRST + 3'(k), 64'd123, 0, SIGN_PLUS, 0, 1, 8'd5));
    foreach (plan[i]) send_item(plan[i]);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 6;  recv_idle_pct = 79; end
        1: begin send_idle_pct = 79; recv_idle_pct = 6;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      repeat (ITEMS_PER_PHASE) begin
        if ($urandom_range(24) == 0) drain();
        send_item(random_item());
      end
      drain();
    end

    // catch any stray beat after the last expected group
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
